// File: rtl/substring_first_match_finder_defines.svh
// Assertion macros shared by the substring first-match finder RTL.
`ifndef SUBSTRING_FIRST_MATCH_FINDER_DEFINES_SVH
`define SUBSTRING_FIRST_MATCH_FINDER_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define SFMF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define SFMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SFMF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SFMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/sfmf_pkg.sv
// Package with constants and types of the substring first-match finder.
`timescale 1ns / 1ps
package sfmf_pkg;

  // Store depth and field widths.
  localparam int PAT_MAX = 32;
  localparam int LEN_W   = 6;
  localparam int SLOT_W  = 5;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 16;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_PATTERN_LENGTH = 1'b0;

  // Request kinds carried on tuser.
  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TEXT    = 1'b1;

  // Result buffer depth.
  localparam int OUT_DEPTH = 2;

  // Per-cell control.
  typedef struct packed {
    logic w_shift;
    logic p_write;
    logic q_load;
    logic q_shift;
    logic q_write;
  } sfmf_cell_ctrl_t;

  // One result item.
  typedef struct packed {
    logic             overflow;
    logic [POS_W-1:0] match_start;
    logic             found;
  } sfmf_result_t;

endpackage

// File: rtl/sfmf_cell.sv
// One cell of the compare chain: a window byte, a pattern byte and an aligned pattern byte.
`timescale 1ns / 1ps
module sfmf_cell (
  input  logic                         clk,
  input  sfmf_pkg::sfmf_cell_ctrl_t    ctrl,
  input  logic [sfmf_pkg::BYTE_W-1:0]  data_byte,
  input  logic [sfmf_pkg::BYTE_W-1:0]  w_in,
  input  logic [sfmf_pkg::BYTE_W-1:0]  q_right,
  output logic [sfmf_pkg::BYTE_W-1:0]  w_out,
  output logic [sfmf_pkg::BYTE_W-1:0]  q_out,
  output logic                         eq
);

  logic [sfmf_pkg::BYTE_W-1:0] w_r;
  logic [sfmf_pkg::BYTE_W-1:0] p_r;
  logic [sfmf_pkg::BYTE_W-1:0] q_r;

  // The window shifts one cell per text byte.
  always_ff @(posedge clk) begin
    if (ctrl.w_shift) begin
      w_r <= w_in;
    end
  end

  // Pattern byte kept at its store slot.
  always_ff @(posedge clk) begin
    if (ctrl.p_write) begin
      p_r <= data_byte;
    end
  end

  // Aligned pattern byte: reloaded and shifted after a length change, or written directly.
  always_ff @(posedge clk) begin
    if (ctrl.q_load) begin
      q_r <= p_r;
    end else if (ctrl.q_shift) begin
      q_r <= q_right;
    end else if (ctrl.q_write) begin
      q_r <= data_byte;
    end
  end

  // Compare the byte this cell holds after the current shift.
  assign eq    = (w_in == q_r);
  assign w_out = w_r;
  assign q_out = q_r;

endmodule

// File: rtl/sfmf_out_buf.sv
// Two-entry result buffer between the compare chain and the output stream.
`timescale 1ns / 1ps
module sfmf_out_buf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  sfmf_pkg::sfmf_result_t  push_data,
  output logic                    full,
  output logic                    out_valid,
  input  logic                    out_ready,
  output sfmf_pkg::sfmf_result_t  out_data
);

  sfmf_pkg::sfmf_result_t mem_r [sfmf_pkg::OUT_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign full      = (cnt_r == 2'(sfmf_pkg::OUT_DEPTH));
  assign out_valid = (cnt_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = out_valid && out_ready;
  assign out_data  = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

// File: rtl/substring_first_match_finder.sv
// Top level of the substring first-match finder: cell chain, text counters and ports.
//
//   Channel   Direction  Transfer when              Contents
//   in_*      input      in_tvalid & in_tready      tuser kind, tdata slot/byte, tlast
//   out_*     output     out_tvalid & out_tready    tdata found/start/overflow
//   cfg_*     input      psel & penable & pwrite    pattern_length at byte address 0
//
// One input transfer per cycle; a final text byte yields its result in the next cycle.
// A write of pattern_length starts a realignment of the aligned pattern chain that
// shifts it into place (none for 0 or above 32); input is held then.
// Input also stalls while both result buffer entries are full.
// Reset is synchronous, active low; the pattern store itself is not cleared.
`timescale 1ns / 1ps
`include "substring_first_match_finder_defines.svh"
module substring_first_match_finder (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [4:0] pattern_slot, [12:5] data_byte, [15:13] zero
  input  logic        in_tuser,   // [0] req_type
  input  logic        in_tlast,   // text_last
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] found, [16:1] match_start, [17] position_overflow
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [sfmf_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [sfmf_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [sfmf_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int PM = sfmf_pkg::PAT_MAX;
  localparam int LW = sfmf_pkg::LEN_W;
  localparam int PW = sfmf_pkg::POS_W;
  localparam int BW = sfmf_pkg::BYTE_W;
  localparam int SW = sfmf_pkg::SLOT_W;

  logic [LW-1:0] len_r;
  logic [LW-1:0] sweep_cnt_r;
  logic [LW-1:0] fill_r;
  logic [PW-1:0] pos_r;
  logic          seen_r;
  logic [PW-1:0] start_r;
  logic          ovf_r;

  logic          cfg_wr;
  logic          cfg_len_wr;
  logic [LW-1:0] cfg_len_val;
  logic          busy;
  logic          buf_full;
  logic          in_acc;
  logic          pat_acc;
  logic          text_acc;
  logic [SW-1:0] in_slot;
  logic [BW-1:0] in_byte;

  logic [BW-1:0] w_chain [PM];
  logic [BW-1:0] q_chain [PM];
  logic [PM-1:0] eq_vec;
  logic [PM-1:0] active_vec;

  logic          len_ok;
  logic          pos_sat;
  logic [PW-1:0] pos_inc;
  logic [LW-1:0] fill_inc;
  logic          hit;
  logic [PW-1:0] start_calc;
  logic          seen_new;
  logic [PW-1:0] start_new;
  sfmf_pkg::sfmf_result_t result;
  sfmf_pkg::sfmf_result_t out_res;

  // Configuration port decode.
  assign cfg_pready  = 1'b1;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_len_wr  = cfg_wr && (cfg_paddr[2] == sfmf_pkg::REG_PATTERN_LENGTH);
  assign cfg_len_val = cfg_pwdata[LW-1:0];
  assign cfg_prdata  = (cfg_paddr[2] == sfmf_pkg::REG_PATTERN_LENGTH) ?
                       {(sfmf_pkg::CFG_DATA_W - LW)'(0), len_r} : '0;

  // Input handshake and field unpacking.
  assign busy      = (sweep_cnt_r != '0);
  assign in_tready = !busy && !buf_full && !cfg_wr;
  assign in_acc    = in_tvalid && in_tready;
  assign pat_acc   = in_acc && (in_tuser == sfmf_pkg::REQ_PATTERN);
  assign text_acc  = in_acc && (in_tuser == sfmf_pkg::REQ_TEXT);
  assign in_slot   = in_tdata[SW-1:0];
  assign in_byte   = in_tdata[SW+BW-1:SW];

  // Chain of compare cells; cell j holds window byte j (0 newest) and pattern byte len-1-j.
  for (genvar j = 0; j < PM; j++) begin : g_cell
    sfmf_pkg::sfmf_cell_ctrl_t ctrl;
    logic [BW-1:0] w_in;
    logic [BW-1:0] q_right;

    if (j == 0) begin : g_head
      assign w_in = in_byte;
    end else begin : g_body
      assign w_in = w_chain[j-1];
    end
    if (j == PM - 1) begin : g_tail
      assign q_right = '0;
    end else begin : g_mid
      assign q_right = q_chain[j+1];
    end

    assign ctrl.w_shift = text_acc;
    assign ctrl.p_write = pat_acc && (in_slot == SW'(PM - 1 - j));
    assign ctrl.q_load  = cfg_len_wr;
    assign ctrl.q_shift = busy;
    assign ctrl.q_write = pat_acc && ({1'b0, in_slot} < len_r) &&
                          ((7'(in_slot) + 7'(j) + 7'd1) == 7'(len_r));
    assign active_vec[j] = (7'(j) < 7'(len_r));

    sfmf_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .data_byte (in_byte),
      .w_in      (w_in),
      .q_right   (q_right),
      .w_out     (w_chain[j]),
      .q_out     (q_chain[j]),
      .eq        (eq_vec[j])
    );
  end

  // Text-side counters and the match test on the shifted window.
  assign len_ok     = (len_r != '0) && (len_r <= LW'(PM));
  assign pos_sat    = (pos_r == sfmf_pkg::POS_MAX);
  assign pos_inc    = pos_sat ? pos_r : pos_r + PW'(1);
  assign fill_inc   = (fill_r < LW'(PM)) ? fill_r + LW'(1) : fill_r;
  assign hit        = len_ok && (fill_inc >= len_r) && (&(eq_vec | ~active_vec));
  assign start_calc = (pos_inc >= PW'(len_r)) ? pos_inc - PW'(len_r) : '0;
  assign seen_new   = seen_r || hit;
  assign start_new  = seen_r ? start_r : start_calc;

  // Result of a final text byte.
  always_comb begin
    result.overflow = ovf_r || pos_sat;
    if (len_r == '0) begin
      result.found       = 1'b1;
      result.match_start = pos_inc;
    end else if (seen_new) begin
      result.found       = 1'b1;
      result.match_start = start_new;
    end else begin
      result.found       = 1'b0;
      result.match_start = '0;
    end
  end

  // Length register and realignment counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      sweep_cnt_r <= '0;
    end else if (cfg_len_wr) begin
      len_r <= cfg_len_val;
      if ((cfg_len_val != '0) && (cfg_len_val <= LW'(PM))) begin
        sweep_cnt_r <= LW'(PM) - cfg_len_val;
      end else begin
        sweep_cnt_r <= '0;
      end
    end else if (busy) begin
      sweep_cnt_r <= sweep_cnt_r - LW'(1);
    end
  end

  // Text state: updated per text byte, cleared after the final one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      pos_r   <= '0;
      seen_r  <= 1'b0;
      start_r <= '0;
      ovf_r   <= 1'b0;
    end else if (text_acc) begin
      if (in_tlast) begin
        fill_r  <= '0;
        pos_r   <= '0;
        seen_r  <= 1'b0;
        start_r <= '0;
        ovf_r   <= 1'b0;
      end else begin
        fill_r  <= fill_inc;
        pos_r   <= pos_inc;
        seen_r  <= seen_new;
        start_r <= start_new;
        ovf_r   <= ovf_r || pos_sat;
      end
    end
  end

  // Result buffer and output packing.
  sfmf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (text_acc && in_tlast),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {6'd0, out_res.overflow, out_res.match_start, out_res.found};

  // Checks on realignment, result delivery and text-state clearing.
  `SFMF_ASSERT_IMPL(a_sweep_holds_input, clk, rst_n, busy, !in_tready, "input taken during realignment")
  `SFMF_ASSERT_NEXT(a_last_gives_result, clk, rst_n, text_acc && in_tlast, out_tvalid, "final byte left no result")
  `SFMF_ASSERT_NEXT(a_text_state_cleared, clk, rst_n, text_acc && in_tlast, (fill_r == '0) && !seen_r && !ovf_r, "text state not cleared")
  `SFMF_ASSERT_IMPL(a_miss_has_zero_start, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata[16:1] == 16'd0, "miss with nonzero start")

endmodule
